// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/ntpd_pkg.sv -----
package ntpd_pkg;

    localparam int unsigned ID_W      = 8;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned DIM_W     = 5;
    localparam int unsigned COORD_W   = 4;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned NBITS_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // pattern codes
    localparam logic [MODE_W-1:0] MODE_TRANSPOSE1 = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRANSPOSE2 = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSAL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BUTTERFLY  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE = 2'd2;

    // settled configuration seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [NBITS_W-1:0] nbits;
        logic [MODE_W-1:0]  mode;
    } cfg_t;

    // restoring divider state, id divided by mesh width
    typedef struct packed {
        logic [ID_W-1:0]    src;
        logic [ID_W-1:0]    num;
        logic [ID_W-1:0]    quo;
        logic [COORD_W-1:0] rem;
    } div_t;

endpackage

// ----- hw/rtl/noc_traffic_pattern_destination_core.sv -----
// pipeline: four register stages, two divider stages of four quotient bits each,
//   then the coordinate stage and the rebuild stage that ends in the output register
// throughput: one request per cycle while dest_ready is high; a low dest_ready holds
//   the output register, and src_ready drops once every stage behind it is full
// reset: asynchronous, active low; pipeline emptied, mesh 8 x 8, transpose1
`include "assert_macros.svh"
module noc_traffic_pattern_destination_core #(
    parameter int unsigned NODE_ID_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ntpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ntpd_pkg::DIM_W-1:0]     cfg_data,
    input  logic                           src_valid,
    output logic                           src_ready,
    input  logic [ntpd_pkg::ID_W-1:0]      source_node,
    output logic                           dest_valid,
    input  logic                           dest_ready,
    output logic [ntpd_pkg::ID_W-1:0]      dest_node
);
    import ntpd_pkg::*;

    // ids narrower than the port keep only their low bits
    localparam logic [ID_W-1:0] ID_MASK = ID_W'((16'd1 << NODE_ID_BITS) - 16'd1);

    cfg_t            cfg;
    div_t            div_in;
    div_t            s1_data;
    div_t            s2_data;
    logic            s1_valid;
    logic            s1_ready;
    logic            s2_valid;
    logic            s2_ready;
    logic [ID_W-1:0] dest_raw;

    // configuration registers and derived id width
    ntpd_cfg #(
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // divider seeded with the masked id
    always_comb
    begin
        div_in.src = source_node & ID_MASK;
        div_in.num = source_node & ID_MASK;
        div_in.quo = '0;
        div_in.rem = '0;
    end

    // upper quotient bits
    ntpd_div_half u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src_valid),
        .in_ready  (src_ready),
        .in_data   (div_in),
        .divisor   (cfg.width),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // lower quotient bits, leaves row in quo and column in rem
    ntpd_div_half u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .divisor   (cfg.width),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // pattern mapping and id rebuild, ends in the output register
    ntpd_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .cfg       (cfg),
        .out_valid (dest_valid),
        .out_ready (dest_ready),
        .dest_raw  (dest_raw)
    );

    assign dest_node = dest_raw & ID_MASK;

    // input only stalls once every stage is full and the output is held
    `ASSERT_HOLDS(a_stall_full, clk, rst_n, (!src_ready) |-> (s1_valid && s2_valid && dest_valid && !dest_ready), "input stalled with a bubble in the pipeline")
    // an accepted request always lands in the first stage
    `ASSERT_NEXT(a_accept_lands, clk, rst_n, src_valid && src_ready, s1_valid, "accepted request lost at the first stage")
    // transposes stay inside the mesh
    `ASSERT_HOLDS(a_transpose_in_mesh, clk, rst_n, (dest_valid && ((cfg.mode == MODE_TRANSPOSE1) || (cfg.mode == MODE_TRANSPOSE2))) |-> (9'(dest_raw) < (9'(cfg.width) * 9'(cfg.height))), "transpose destination outside the mesh")
    // bit patterns never set bit nbits or any bit above it
    `ASSERT_HOLDS(a_pattern_width, clk, rst_n, (dest_valid && ((cfg.mode == MODE_REVERSAL) || (cfg.mode == MODE_SHUFFLE) || (cfg.mode == MODE_BUTTERFLY))) |-> ((dest_raw >> cfg.nbits) == '0), "bit pattern wider than nbits")

endmodule

// ----- hw/rtl/ntpd_cfg.sv -----
module ntpd_cfg #(
    parameter int unsigned NODE_ID_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ntpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ntpd_pkg::DIM_W-1:0]   cfg_data,
    output ntpd_pkg::cfg_t               cfg
);
    import ntpd_pkg::*;

    localparam logic [NBITS_W-1:0] ID_BITS_CAP = NBITS_W'(NODE_ID_BITS);
    localparam logic [NBITS_W-1:0] NBITS_RST   =
        (NODE_ID_BITS < 6) ? NBITS_W'(NODE_ID_BITS) : NBITS_W'(6);

    logic [DIM_W-1:0]   mesh_width_reg;
    logic [DIM_W-1:0]   mesh_height_reg;
    logic [MODE_W-1:0]  pattern_mode_reg;
    logic [NBITS_W-1:0] nbits_reg;
    logic [NBITS_W-1:0] nbits_next;
    logic [DIM_W-1:0]   w_fix;
    logic [DIM_W-1:0]   h_fix;
    logic [8:0]         nodes;
    logic [NBITS_W-1:0] cnt;

    // zero reads as one, anything above sixteen as sixteen
    function automatic logic [DIM_W-1:0] dim_fix(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = 5'd1;
        else if (v > 5'd16)
            r = 5'd16;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign w_fix     = dim_fix(mesh_width_reg);
    assign h_fix     = dim_fix(mesh_height_reg);

    // ceil(log2(nodes)) as a count of powers below the node count
    always_comb
    begin
        nodes = {4'b0, w_fix} * {4'b0, h_fix};
        cnt   = '0;
        for (int n = 0; n < 8; n++)
        begin
            if (nodes > (9'd1 << n))
                cnt = cnt + 4'd1;
        end
        nbits_next = (cnt > ID_BITS_CAP) ? ID_BITS_CAP : cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_width_reg   <= 5'd8;
            mesh_height_reg  <= 5'd8;
            pattern_mode_reg <= MODE_TRANSPOSE1;
            nbits_reg        <= NBITS_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MESH_WIDTH:   mesh_width_reg   <= cfg_data;
                    CFG_MESH_HEIGHT:  mesh_height_reg  <= cfg_data;
                    CFG_PATTERN_MODE: pattern_mode_reg <= cfg_data[MODE_W-1:0];
                    default:          ;
                endcase
            end
            nbits_reg <= nbits_next;
        end
    end

    assign cfg.width  = w_fix;
    assign cfg.height = h_fix;
    assign cfg.nbits  = nbits_reg;
    assign cfg.mode   = pattern_mode_reg;

endmodule

// ----- hw/rtl/ntpd_div_half.sv -----
module ntpd_div_half (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  ntpd_pkg::div_t           in_data,
    input  logic [ntpd_pkg::DIM_W-1:0] divisor,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ntpd_pkg::div_t           out_data
);
    import ntpd_pkg::*;

    div_t             d;
    div_t             data_reg;
    logic             valid_reg;
    logic [DIM_W-1:0] t;
    logic             qb;

    // four restoring steps, one quotient bit each
    always_comb
    begin
        d = in_data;
        for (int k = 0; k < 4; k++)
        begin
            t  = {d.rem, d.num[ID_W-1]};
            qb = (t >= divisor);
            if (qb)
                t = t - divisor;
            d.rem = t[COORD_W-1:0];
            d.num = {d.num[ID_W-2:0], 1'b0};
            d.quo = {d.quo[ID_W-2:0], qb};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= d;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/ntpd_map.sv -----
module ntpd_map (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ntpd_pkg::div_t          in_data,
    input  ntpd_pkg::cfg_t          cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ntpd_pkg::ID_W-1:0] dest_raw
);
    import ntpd_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [ID_W-1:0]    pat;
        logic               is_t;
    } map_t;

    map_t               m_next;
    map_t               m_reg;
    logic               v3_reg;
    logic               v4_reg;
    logic               ready4;
    logic [ID_W-1:0]    dest_next;
    logic [ID_W-1:0]    dest_reg;
    logic [ID_W-1:0]    y;
    logic [COORD_W-1:0] x;
    logic [ID_W-1:0]    src;
    logic [DIM_W-1:0]   wm1;
    logic [DIM_W-1:0]   hm1;
    logic [DIM_W-1:0]   dx_diff;
    logic [DIM_W-1:0]   dy_diff;
    logic               y_over;
    logic               x_over;
    logic [NBITS_W-1:0] top;
    logic [NBITS_W-1:0] ri;
    logic [ID_W-1:0]    pat_next;
    logic [8:0]         prod;
    logic [8:0]         sum;

    // coordinates and their clamp
    always_comb
    begin
        y       = in_data.quo;
        x       = in_data.rem;
        src     = in_data.src;
        wm1     = cfg.width - 5'd1;
        hm1     = cfg.height - 5'd1;
        y_over  = y > {3'b000, wm1};
        x_over  = {1'b0, x} > hm1;
        dx_diff = wm1 - y[DIM_W-1:0];
        dy_diff = hm1 - {1'b0, x};
        m_next.pat  = pat_next;
        m_next.is_t = (cfg.mode == MODE_TRANSPOSE1) || (cfg.mode == MODE_TRANSPOSE2);
        if (cfg.mode == MODE_TRANSPOSE1)
        begin
            m_next.dx = y_over ? '0 : dx_diff[COORD_W-1:0];
            m_next.dy = x_over ? '0 : dy_diff[COORD_W-1:0];
        end
        else
        begin
            m_next.dx = y_over ? wm1[COORD_W-1:0] : y[COORD_W-1:0];
            m_next.dy = x_over ? hm1[COORD_W-1:0] : x;
        end
    end

    // bit patterns over the low nbits of the id
    always_comb
    begin
        top      = cfg.nbits - 4'd1;
        ri       = '0;
        pat_next = '0;
        case (cfg.mode)
            MODE_REVERSAL:
            begin
                for (int i = 0; i < ID_W; i++)
                begin
                    ri = top - NBITS_W'(i);
                    if (NBITS_W'(i) < cfg.nbits)
                        pat_next[i] = src[ri[IDX_W-1:0]];
                end
            end
            MODE_SHUFFLE:
            begin
                if (cfg.nbits != '0)
                    pat_next[0] = src[top[IDX_W-1:0]];
                for (int i = 1; i < ID_W; i++)
                begin
                    if (NBITS_W'(i) < cfg.nbits)
                        pat_next[i] = src[i-1];
                end
            end
            MODE_BUTTERFLY:
            begin
                for (int i = 0; i < ID_W; i++)
                begin
                    if (NBITS_W'(i) < cfg.nbits)
                        pat_next[i] = src[i];
                end
                if (cfg.nbits != '0)
                begin
                    pat_next[0]              = src[top[IDX_W-1:0]];
                    pat_next[top[IDX_W-1:0]] = src[0];
                end
            end
            default:
            begin
                pat_next = '0;
            end
        endcase
    end

    // rebuild the row-major id
    always_comb
    begin
        prod      = {5'b0, m_reg.dy} * {4'b0, cfg.width};
        sum       = prod + {5'b0, m_reg.dx};
        dest_next = m_reg.is_t ? sum[ID_W-1:0] : m_reg.pat;
    end

    assign ready4   = !v4_reg || out_ready;
    assign in_ready = !v3_reg || ready4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v3_reg <= in_valid;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            m_reg <= m_next;
        if (ready4 && v3_reg)
            dest_reg <= dest_next;
    end

    assign out_valid = v4_reg;
    assign dest_raw  = dest_reg;

endmodule

// ----- verif/tb_noc_traffic_pattern_destination_core.sv -----
module tb_noc_traffic_pattern_destination_core;
    import ntpd_pkg::*;

    // pipeline depth from an accepted request to its result
    localparam int LATENCY        = 4;
    // long receiver hold-off, enough to fill the pipeline and stall the sender
    localparam int HOLD_CYCLES    = 60;
    // cycles with no handshake at all before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1350;

    // write to the spare index, which maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED         = 2'd3;
    // pattern codes with no pattern behind them
    localparam logic [MODE_W-1:0]    MODE_UNKNOWN_FIRST = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_UNKNOWN_LAST  = 3'd7;

    typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     data;
        logic [ID_W-1:0]      src;
        bit                   pinned;
        logic [ID_W-1:0]      dest;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 src_valid;
    logic                 src_ready;
    logic [ID_W-1:0]      source_node;
    logic                 dest_valid;
    logic                 dest_ready = 1'b0;
    logic [ID_W-1:0]      dest_node;

    // typed-in expectation travelling with the current request
    bit                   pin_use;
    logic [ID_W-1:0]      pin_dest;

    // our own copy of the register file
    logic [DIM_W-1:0]     mesh_w_cfg = 5'd8;
    logic [DIM_W-1:0]     mesh_h_cfg = 5'd8;
    logic [MODE_W-1:0]    mode_cfg   = MODE_TRANSPOSE1;

    logic [ID_W-1:0]      dest_expected_q[$];
    dir_row_t             dir_rows[$];
    int                   fault_count  = 0;
    int                   items_sent   = 0;
    int                   stall_cycles = 0;

    // receiver pattern state; hold-offs are asked for by bumping hold_reqs
    int                   hold_reqs    = 0;
    int                   hold_seen    = 0;
    int                   hold_left    = 0;
    int                   pattern_left = 0;
    int                   ready_pct    = 100;

    noc_traffic_pattern_destination_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .source_node (source_node),
        .dest_valid  (dest_valid),
        .dest_ready  (dest_ready),
        .dest_node   (dest_node)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register values outside 1..16 behave as the nearest end of the range
    function automatic int dim_clip(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 16)
            return 16;
        return int'(v);
    endfunction

    // destination id under the pattern held in our register copy
    function automatic logic [ID_W-1:0] route_dest(input logic [ID_W-1:0] src_id);
        int              w;
        int              h;
        int              nbits;
        int              x;
        int              y;
        int              dx;
        int              dy;
        logic [ID_W-1:0] d;
        w     = dim_clip(mesh_w_cfg);
        h     = dim_clip(mesh_h_cfg);
        nbits = 0;
        d     = '0;
        while (nbits < 16 && (1 << nbits) < w * h)
            nbits++;
        if (nbits > ID_W)
            nbits = ID_W;
        case (mode_cfg)
            MODE_TRANSPOSE1, MODE_TRANSPOSE2:
            begin
                x = int'(src_id) % w;
                y = int'(src_id) / w;
                if (mode_cfg == MODE_TRANSPOSE1)
                begin
                    dx = w - 1 - y;
                    dy = h - 1 - x;
                end
                else
                begin
                    dx = y;
                    dy = x;
                end
                dx = (dx < 0) ? 0 : ((dx > w - 1) ? w - 1 : dx);
                dy = (dy < 0) ? 0 : ((dy > h - 1) ? h - 1 : dy);
                d  = ID_W'(dy * w + dx);
            end
            MODE_REVERSAL:
            begin
                for (int i = 0; i < nbits; i++)
                    d[i] = src_id[nbits - 1 - i];
            end
            MODE_SHUFFLE:
            begin
                if (nbits > 0)
                begin
                    for (int i = 0; i + 1 < nbits; i++)
                        d[i + 1] = src_id[i];
                    d[0] = src_id[nbits - 1];
                end
            end
            MODE_BUTTERFLY:
            begin
                if (nbits > 0)
                begin
                    for (int i = 1; i + 1 < nbits; i++)
                        d[i] = src_id[i];
                    d[0]         = src_id[nbits - 1];
                    d[nbits - 1] = src_id[0];
                end
            end
            default:
                d = '0;
        endcase
        return d;
    endfunction

    // mostly ids inside the mesh, the rest anywhere in the id range
    function automatic logic [ID_W-1:0] pick_source(input int nodes);
        if ($urandom_range(0, 99) < 85)
            return ID_W'($urandom_range(0, nodes - 1));
        return ID_W'($urandom_range(0, 255));
    endfunction

    // mesh dimension with the extremes and the out-of-range values weighted up
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 5'd1;
            1:       return 5'd16;
            2:       return 5'd0;
            3:       return DIM_W'($urandom_range(17, 31));
            default: return DIM_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        dir_row_t row;
        row = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic add_send(input logic [ID_W-1:0] src, input bit pinned,
                            input logic [ID_W-1:0] dest);
        dir_row_t row;
        row = '{ROW_SEND, '0, '0, src, pinned, dest};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // one register write; valid stays up when another write follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // one request; valid is left high so that back-to-back requests need no gap
    task automatic send_request(input logic [ID_W-1:0] src, input bit pinned,
                                input logic [ID_W-1:0] dest);
        src_valid   <= 1'b1;
        source_node <= src;
        pin_use     <= pinned;
        pin_dest    <= dest;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        src_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // stop offering, wait for every result, then let the pipeline go quiet
    task automatic settle_block();
        src_valid <= 1'b0;
        @(posedge clk);
        while (dest_expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    // receiver: ready probability changes in stretches, with long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_reqs;
        end
        if (pattern_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pct = 100;
                1:       ready_pct = 80;
                2:       ready_pct = 50;
                default: ready_pct = 15;
            endcase
            pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            dest_ready <= 1'b0;
        end
        else
            dest_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    // scoreboard: register copy, expectations on accepted requests, checks on results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MESH_WIDTH:   mesh_w_cfg = cfg_data;
                    CFG_MESH_HEIGHT:  mesh_h_cfg = cfg_data;
                    CFG_PATTERN_MODE: mode_cfg   = cfg_data[MODE_W-1:0];
                    default:          ;
                endcase
            end
            if (src_valid && src_ready)
                dest_expected_q.insert(dest_expected_q.size(),
                                       pin_use ? pin_dest : route_dest(source_node));
            if (dest_valid && dest_ready)
            begin
                if (dest_expected_q.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, got %0d",
                             $time, dest_node);
                    fault_count++;
                end
                else
                begin
                    if (dest_node !== dest_expected_q[0])
                    begin
                        $display("%0t: dest_node mismatch, expected %0d, got %0d",
                                 $time, dest_expected_q[0], dest_node);
                        fault_count++;
                    end
                    void'(dest_expected_q.pop_front());
                end
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (rst_n && !(src_valid && src_ready) && !(dest_valid && dest_ready)
            && !(cfg_valid && cfg_ready))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int               nodes;
        int               phase;
        int               phase_left;
        int               burst;
        int               gap;
        logic [DIM_W-1:0] w_pick;
        logic [DIM_W-1:0] h_pick;
        logic [MODE_W-1:0] m_pick;
        bit               last;

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        src_valid   <= 1'b0;
        source_node <= '0;
        pin_use     <= 1'b0;
        pin_dest    <= '0;

        // directed part: reset mesh 8 x 8 under transpose1 first
        add_send(8'd0, 1'b1, 8'd63);          // corner maps to the far corner
        add_send(8'd63, 1'b1, 8'd0);
        add_send(8'd255, 1'b1, 8'd0);         // id beyond the mesh, clamped back in
        add_send(8'd9, 1'b0, '0);
        add_write(CFG_PATTERN_MODE, MODE_TRANSPOSE2);
        add_send(8'd255, 1'b0, '0);
        add_send(8'd10, 1'b0, '0);
        add_write(CFG_PATTERN_MODE, MODE_REVERSAL);
        add_send(8'd1, 1'b0, '0);
        add_send(8'd255, 1'b0, '0);
        add_write(CFG_PATTERN_MODE, MODE_SHUFFLE);
        add_send(8'h20, 1'b0, '0);
        add_write(CFG_PATTERN_MODE, MODE_BUTTERFLY);
        add_send(8'h21, 1'b0, '0);
        // full 16 x 16 mesh, every id bit in play
        add_write(CFG_MESH_WIDTH, 5'd16);
        add_write(CFG_MESH_HEIGHT, 5'd16);
        add_send(8'h80, 1'b0, '0);
        add_send(8'h01, 1'b0, '0);
        // zero dimensions read as one: single node, bit patterns give zero
        add_write(CFG_MESH_WIDTH, 5'd0);
        add_write(CFG_MESH_HEIGHT, 5'd0);
        add_send(8'd255, 1'b1, 8'd0);
        // oversized dimensions read as sixteen, unknown pattern gives zero
        add_write(CFG_MESH_WIDTH, 5'd31);
        add_write(CFG_MESH_HEIGHT, 5'd17);
        add_write(CFG_PATTERN_MODE, {2'b11, MODE_UNKNOWN_LAST});
        add_write(CFG_UNUSED, 5'd0);          // spare index must leave everything alone
        add_send(8'd255, 1'b1, 8'd0);
        add_write(CFG_PATTERN_MODE, MODE_TRANSPOSE1);
        add_send(8'd255, 1'b0, '0);

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                if (i == 0 || dir_rows[i - 1].kind != ROW_WRITE)
                    settle_block();
                last = (i + 1 >= dir_rows.size()) || (dir_rows[i + 1].kind != ROW_WRITE);
                write_reg(dir_rows[i].idx, dir_rows[i].data, last);
            end
            else
                send_request(dir_rows[i].src, dir_rows[i].pinned, dir_rows[i].dest);
        end

        // random part: phases of one setting each, written while the block is idle
        phase      = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle_block();
            w_pick = pick_dim();
            h_pick = pick_dim();
            if ($urandom_range(0, 9) < 8)
                m_pick = MODE_W'($urandom_range(MODE_TRANSPOSE1, MODE_BUTTERFLY));
            else
                m_pick = MODE_W'($urandom_range(MODE_UNKNOWN_FIRST, MODE_UNKNOWN_LAST));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED, DIM_W'($urandom_range(0, 31)), 1'b0);
            write_reg(CFG_MESH_WIDTH, w_pick, 1'b0);
            write_reg(CFG_MESH_HEIGHT, h_pick, 1'b0);
            // spare upper data bits on the mode write are random
            write_reg(CFG_PATTERN_MODE, {2'($urandom_range(0, 3)), m_pick}, 1'b1);
            nodes      = dim_clip(w_pick) * dim_clip(h_pick);
            phase_left = $urandom_range(30, 90);

            // one phase holds the receiver off while requests keep coming
            if (phase == 2)
            begin
                hold_reqs++;
                repeat (40)
                    send_request(pick_source(nodes), 1'b0, '0);
            end

            while (phase_left > 0)
            begin
                burst = $urandom_range(1, 24);
                if (burst > phase_left)
                    burst = phase_left;
                repeat (burst)
                    send_request(pick_source(nodes), 1'b0, '0);
                phase_left -= burst;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                // now and then pause mid-phase until all results are back
                if ($urandom_range(0, 24) == 0)
                    settle_block();
                else if (gap > 0)
                    idle_sender(gap);
            end
            phase++;
        end

        settle_block();
        if (fault_count == 0 && dest_expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- noc_traffic_pattern_destination_core.f -----
+incdir+hw/rtl
hw/rtl/ntpd_pkg.sv
hw/rtl/ntpd_cfg.sv
hw/rtl/ntpd_div_half.sv
hw/rtl/ntpd_map.sv
hw/rtl/noc_traffic_pattern_destination_core.sv
verif/tb_noc_traffic_pattern_destination_core.sv
